>>> hw/rtl/sorted_key_set_macros.svh
// Assertion helpers used by the checker file.
`ifndef SORTED_KEY_SET_MACROS_SVH
`define SORTED_KEY_SET_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SKSET_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SKSET_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/skset_pkg.sv
package skset_pkg;

    // Operation codes carried in the low bits of s_tdata
    localparam logic [1:0] CMD_MEMBER = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam int CMD_W     = 2;
    localparam int KEY_IN_W  = 16;
    localparam int COUNT_W   = 9;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the broadcast key
        logic upd_en;   // apply the shift decided this cycle
        logic ins;      // open a slot at the insert position
        logic del;      // close the slot of the matching key
    } skset_ctrl_t;

endpackage

>>> hw/rtl/skset_cell.sv
module skset_cell #(
    parameter int KEY_BITS = 16
) (
    input  logic                 aclk,
    input  skset_pkg::skset_ctrl_t ctrl,
    input  logic [KEY_BITS-1:0]  key_bcast,
    input  logic                 valid,
    input  logic [KEY_BITS-1:0]  left_key,
    input  logic                 left_lt,
    input  logic [KEY_BITS-1:0]  right_key,
    output logic [KEY_BITS-1:0]  key_out,
    output logic                 lt_out,
    output logic                 eq_out
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                lt_reg;
    logic                eq_reg;

    // Cells at or past the target position move; lt_reg is a thermometer along the chain.
    always_comb begin
        key_next = key_reg;
        if (ctrl.upd_en && !lt_reg) begin
            if (ctrl.ins) begin
                key_next = left_lt ? key_bcast : left_key;
            end else if (ctrl.del) begin
                key_next = right_key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (ctrl.cmp_en) begin
            lt_reg <= valid && (key_reg < key_bcast);
            eq_reg <= valid && (key_reg == key_bcast);
        end
    end

    assign key_out = key_reg;
    assign lt_out  = lt_reg;
    assign eq_out  = eq_reg;

endmodule

>>> hw/rtl/sorted_key_set.sv
// Sorted set of distinct keys held in a chain of cells, ascending from cell 0.
// Input channel s_*: one operation per item, cmd in s_tdata[1:0]
// (member query, insert, delete) and the key in s_tdata[17:2].
// Result channel m_*: one result per item with success, full_reject and the
// entry count after the operation.
// Each item passes through accept, a compare cycle in which every cell
// registers its less-than and match flags against the broadcast key, and an
// update cycle in which the match flags are ORed and the cells at or past
// the insert/delete position shift by one toward or away from it at once.
// m_tvalid is set as the update cycle completes and the block returns to
// idle; only there is a new item taken, so items never overlap.
// A result waiting in the output register does not block acceptance; only
// the update cycle holds while the output register is still occupied, so a
// stalled receiver stalls the chain and then s_tready.
// Reset empties the set (count to zero); cell contents are not cleared and
// are only looked at below the count. No clearing pass is needed.
module sorted_key_set #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [1:0] cmd, [17:2] key, [23:18] zero
    input  logic [skset_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] success, [1] full_reject, [10:2] entry_count, [15:11] zero
    output logic [skset_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } state_t;

    state_t                 state_reg;
    logic [1:0]             cmd_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   m_tvalid_reg;
    logic                   success_reg;
    logic                   full_rej_reg;
    logic [skset_pkg::COUNT_W-1:0] entry_count_reg;

    logic [31:0]            key_ext;
    logic [31:0]            count_ext;
    logic                   present;
    logic                   is_full;
    logic                   out_free;
    logic                   do_ins;
    logic                   do_del;
    logic                   success;
    logic                   full_rej;
    skset_pkg::skset_ctrl_t ctrl;

    logic [KEY_BITS-1:0]    key_vec [CAPACITY];
    logic [CAPACITY-1:0]    lt_vec;
    logic [CAPACITY-1:0]    eq_vec;

    assign key_ext = {{(32 - skset_pkg::KEY_IN_W){1'b0}},
                      s_tdata[skset_pkg::CMD_W +: skset_pkg::KEY_IN_W]};

    assign present  = |eq_vec;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        do_ins   = (cmd_reg == skset_pkg::CMD_INSERT) && !present && !is_full;
        do_del   = (cmd_reg == skset_pkg::CMD_DELETE) && present;
        full_rej = (cmd_reg == skset_pkg::CMD_INSERT) && !present && is_full;
        success  = ((cmd_reg == skset_pkg::CMD_MEMBER) && present) || do_ins || do_del;
        if (do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_del) begin
            count_next = count_reg - CNT_W'(1);
        end else begin
            count_next = count_reg;
        end
    end

    assign count_ext = {{(32 - CNT_W){1'b0}}, count_next};

    assign ctrl.cmp_en = (state_reg == ST_CMP);
    assign ctrl.upd_en = (state_reg == ST_UPD) && out_free;
    assign ctrl.ins    = do_ins;
    assign ctrl.del    = do_del;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            logic [KEY_BITS-1:0] left_key;
            logic                left_lt;
            logic [KEY_BITS-1:0] right_key;
            logic                cell_valid;

            // Cell 0 has everything before it "less than", so it is the slot when its own lt is low.
            if (i == 0) begin : g_first
                assign left_key = key_reg;
                assign left_lt  = 1'b1;
            end else begin : g_mid
                assign left_key = key_vec[i-1];
                assign left_lt  = lt_vec[i-1];
            end
            if (i == CAPACITY - 1) begin : g_last
                assign right_key = key_vec[i];
            end else begin : g_inner
                assign right_key = key_vec[i+1];
            end

            assign cell_valid = (CNT_W'(i) < count_reg);

            skset_cell #(
                .KEY_BITS (KEY_BITS)
            ) u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl),
                .key_bcast (key_reg),
                .valid     (cell_valid),
                .left_key  (left_key),
                .left_lt   (left_lt),
                .right_key (right_key),
                .key_out   (key_vec[i]),
                .lt_out    (lt_vec[i]),
                .eq_out    (eq_vec[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // a new result loaded this edge takes precedence over the drain
            if (m_tvalid_reg && m_tready && !ctrl.upd_en) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    state_reg <= ST_UPD;
                end
                ST_UPD: begin
                    if (out_free) begin
                        count_reg    <= count_next;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
        if (state_reg == ST_IDLE && s_tvalid) begin
            cmd_reg <= s_tdata[skset_pkg::CMD_W-1:0];
            key_reg <= key_ext[KEY_BITS-1:0];
        end
        if (state_reg == ST_UPD && out_free) begin
            success_reg     <= success;
            full_rej_reg    <= full_rej;
            entry_count_reg <= count_ext[skset_pkg::COUNT_W-1:0];
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(skset_pkg::M_TDATA_W - skset_pkg::COUNT_W - 2){1'b0}},
                       entry_count_reg, full_rej_reg, success_reg};

endmodule

>>> hw/rtl/skset_checker.sv
`include "sorted_key_set_macros.svh"

module skset_checker #(
    parameter int CAPACITY = 256
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [skset_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic [31:0] cap_ext;
    logic        s_fire;

    assign cap_ext = 32'(CAPACITY);
    assign s_fire  = s_tvalid && s_tready;

    `SKSET_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result changed while stalled")

    `SKSET_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_fire,
        !s_tready, "second item taken while one is in flight")

    `SKSET_ASSERT_NOW(a_flags_exclusive, aclk, aresetn, m_tvalid,
        !(m_tdata[0] && m_tdata[1]), "success and full_reject both set")

    `SKSET_ASSERT_NOW(a_reject_when_full, aclk, aresetn, m_tvalid && m_tdata[1],
        m_tdata[10:2] == cap_ext[8:0], "full_reject without a full store")

    `SKSET_ASSERT_NOW(a_no_data_extra, aclk, aresetn, m_tvalid,
        m_tdata[15:11] == 5'd0, "pad bits of result not zero")

endmodule

bind sorted_key_set skset_checker #(
    .CAPACITY (CAPACITY)
) u_skset_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
